@@ hdl/aspect_fit_zoom_pan_resampler_assert.svh @@
// Assertion helpers used by the resampler top level.
`ifndef ASPECT_FIT_ZOOM_PAN_RESAMPLER_ASSERT_SVH
`define ASPECT_FIT_ZOOM_PAN_RESAMPLER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define AFZP_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("afzp assertion failed");

// Next-cycle implication, disabled while reset is high.
`define AFZP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("afzp assertion failed");

`endif

@@ hdl/afzp_pkg.sv @@
// ---------------------------------------------------------------------------
// afzp_pkg
// Types and constants of the aspect-fit zoom/pan resampler.
// ---------------------------------------------------------------------------
package afzp_pkg;

   // geometry words are wide enough for any supported screen size
   localparam int GEO_W = 16;
   localparam int IMG_W = 16;
   localparam int PAN_W = 12;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FULLSCREEN   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ZOOM_STEP    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PAN_X        = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_PAN_Y        = 3'd5;

   typedef struct packed {
      logic [8:0] win_x;
      logic [7:0] win_y;
   } afzp_req_type;

   typedef struct packed {
      logic [15:0] src_x;
      logic [15:0] src_y;
      logic [8:0]  scr_x;
      logic [7:0]  scr_y;
      logic        visible;
   } afzp_rsp_type;

   // per-configuration geometry, stable while transactions are in flight
   typedef struct packed {
      logic [IMG_W-1:0] iw;
      logic [IMG_W-1:0] ih;
      logic [GEO_W-1:0] vw;
      logic [GEO_W-1:0] vh;
      logic [GEO_W-1:0] px;
      logic [GEO_W-1:0] py;
      logic [GEO_W-1:0] svw;
      logic [GEO_W-1:0] svh;
      logic [GEO_W-1:0] ddx;
      logic [GEO_W-1:0] ddy;
      logic [GEO_W-1:0] tw;
      logic [GEO_W-1:0] ty;
      logic [GEO_W-1:0] tyth;
   } afzp_geo_type;

endpackage

@@ hdl/afzp_geom.sv @@
// ---------------------------------------------------------------------------
// afzp_geom
// Configuration registers and the sequencer that derives the fitted,
// zoomed and panned window geometry with a bit-serial divider.
// ---------------------------------------------------------------------------
module afzp_geom import afzp_pkg::*; #(
   parameter int SCREEN_WIDTH   = 320,
   parameter int SCREEN_HEIGHT  = 240,
   parameter int CONTENT_TOP    = 23,
   parameter int CONTENT_HEIGHT = 195
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata,
   output logic                 busy,
   output afzp_geo_type         geo
);

   localparam int DVD_W = 2 * GEO_W;
   localparam int CNT_W = $clog2(DVD_W);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_SEL  = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_FIT  = 3'd4;
   localparam logic [2:0] ST_WIN  = 3'd5;

   localparam logic [GEO_W-1:0] TW = GEO_W'(SCREEN_WIDTH);

   logic [IMG_W-1:0] iw_ff, ih_ff;
   logic             fs_ff;
   logic [1:0]       zoom_ff;
   logic [PAN_W-1:0] panx_ff, pany_ff;
   logic [2:0]       state_ff, state_in;
   logic [DVD_W-1:0] pa_ff, pb_ff, dvd_ff, dvd_in;
   logic [IMG_W:0]   rem_ff, rem_in;
   logic [IMG_W-1:0] dvs_ff;
   logic             land_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [GEO_W-1:0] vw_ff, vh_ff;
   afzp_geo_type     geo_ff;

   logic             band;
   logic [IMG_W-1:0] iwe, ihe;
   logic [GEO_W-1:0] th, ty;
   logic [IMG_W+1:0] r2;
   logic             ge;
   logic [GEO_W-1:0] bw, bh, svw, svh, pmx, pmy, pxs, pys;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         iw_ff   <= IMG_W'(1);
         ih_ff   <= IMG_W'(1);
         fs_ff   <= 1'b0;
         zoom_ff <= 2'd0;
         panx_ff <= '0;
         pany_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:  iw_ff   <= csr_wdata;
            REG_IMAGE_HEIGHT: ih_ff   <= csr_wdata;
            REG_FULLSCREEN:   fs_ff   <= csr_wdata[0];
            REG_ZOOM_STEP:    zoom_ff <= csr_wdata[1:0];
            REG_PAN_X:        panx_ff <= csr_wdata[PAN_W-1:0];
            REG_PAN_Y:        pany_ff <= csr_wdata[PAN_W-1:0];
            default: ;
         endcase
      end
   end

   // viewport selection
   always_comb begin
      band = !(fs_ff || (zoom_ff != 2'd0));
      iwe  = (iw_ff == '0) ? IMG_W'(1) : iw_ff;
      ihe  = (ih_ff == '0) ? IMG_W'(1) : ih_ff;
      th   = band ? GEO_W'(CONTENT_HEIGHT) : GEO_W'(SCREEN_HEIGHT);
      ty   = band ? GEO_W'(CONTENT_TOP) : '0;
   end

   // one restoring division step
   always_comb begin
      r2     = {rem_ff, dvd_ff[DVD_W-1]};
      ge     = r2 >= (IMG_W+2)'(dvs_ff);
      rem_in = ge ? (IMG_W+1)'(r2 - (IMG_W+2)'(dvs_ff)) : r2[IMG_W:0];
      dvd_in = {dvd_ff[DVD_W-2:0], ge};
   end

   // fitted size and window terms
   always_comb begin
      bw  = land_ff ? TW : dvd_ff[GEO_W-1:0];
      bh  = land_ff ? dvd_ff[GEO_W-1:0] : th;
      bw  = (bw == '0) ? GEO_W'(1) : bw;
      bh  = (bh == '0) ? GEO_W'(1) : bh;
      svw = (vw_ff < TW) ? vw_ff : TW;
      svh = (vh_ff < th) ? vh_ff : th;
      pmx = (vw_ff > TW) ? vw_ff - TW : '0;
      pmy = (vh_ff > th) ? vh_ff - th : '0;
      pxs = (GEO_W'(panx_ff) < pmx) ? GEO_W'(panx_ff) : pmx;
      pys = (GEO_W'(pany_ff) < pmy) ? GEO_W'(pany_ff) : pmy;
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: state_in = ST_IDLE;
         ST_MUL:  state_in = ST_SEL;
         ST_SEL:  state_in = ST_DIV;
         ST_DIV:  state_in = (cnt_ff == CNT_W'(DVD_W - 1)) ? ST_FIT : ST_DIV;
         ST_FIT:  state_in = ST_WIN;
         ST_WIN:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
      if (csr_valid) state_in = ST_MUL;
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_MUL;
      else       state_ff <= state_in;
   end

   // datapath of the sequencer
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_MUL: begin
            pa_ff <= DVD_W'(iwe) * DVD_W'(th);
            pb_ff <= DVD_W'(ihe) * DVD_W'(TW);
         end
         ST_SEL: begin
            land_ff <= pa_ff >= pb_ff;
            dvd_ff  <= (pa_ff >= pb_ff) ? pb_ff : pa_ff;
            dvs_ff  <= (pa_ff >= pb_ff) ? iwe : ihe;
            rem_ff  <= '0;
            cnt_ff  <= '0;
         end
         ST_DIV: begin
            dvd_ff <= dvd_in;
            rem_ff <= rem_in;
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
         ST_FIT: begin
            vw_ff <= bw << zoom_ff;
            vh_ff <= bh << zoom_ff;
         end
         ST_WIN: begin
            geo_ff.iw   <= iwe;
            geo_ff.ih   <= ihe;
            geo_ff.vw   <= vw_ff;
            geo_ff.vh   <= vh_ff;
            geo_ff.px   <= pxs;
            geo_ff.py   <= pys;
            geo_ff.svw  <= svw;
            geo_ff.svh  <= svh;
            geo_ff.ddx  <= (TW - svw) >> 1;
            geo_ff.ddy  <= ty + ((th - svh) >> 1);
            geo_ff.tw   <= TW;
            geo_ff.ty   <= ty;
            geo_ff.tyth <= ty + th;
         end
         default: ;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);
   assign geo  = geo_ff;

endmodule

@@ hdl/afzp_div_pipe.sv @@
// ---------------------------------------------------------------------------
// afzp_div_pipe
// Pipelined restoring divider, one quotient bit per register stage,
// with a sideband that travels alongside the operands.
// ---------------------------------------------------------------------------
module afzp_div_pipe import afzp_pkg::*; #(
   parameter int DW = 16,
   parameter int QW = 16,
   parameter int SW = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [DW+QW:0]      in_num,
   input  logic [DW-1:0]       den,
   input  logic [SW-1:0]       in_side,
   output logic                out_valid,
   output logic [QW-1:0]       out_quot,
   output logic [SW-1:0]       out_side
);

   localparam int RW = DW + 1;

   logic          v_ff    [QW];
   logic [RW-1:0] rem_ff  [QW];
   logic [QW-1:0] lq_ff   [QW];
   logic [SW-1:0] side_ff [QW];

   genvar s;
   generate
      for (s = 0; s < QW; s++) begin : g_stage
         logic          v_src;
         logic [RW-1:0] rem_src;
         logic [QW-1:0] lq_src;
         logic [SW-1:0] side_src;
         logic [RW:0]   r2;
         logic          ge;

         if (s == 0) begin : g_first
            assign v_src    = in_valid;
            assign rem_src  = in_num[DW+QW:QW];
            assign lq_src   = in_num[QW-1:0];
            assign side_src = in_side;
         end else begin : g_next
            assign v_src    = v_ff[s-1];
            assign rem_src  = rem_ff[s-1];
            assign lq_src   = lq_ff[s-1];
            assign side_src = side_ff[s-1];
         end

         // trial subtract of the divisor
         assign r2 = {rem_src, lq_src[QW-1]};
         assign ge = r2 >= (RW+1)'(den);

         always_ff @(posedge clock) begin
            if (reset) v_ff[s] <= 1'b0;
            else       v_ff[s] <= v_src;
         end

         always_ff @(posedge clock) begin
            rem_ff[s]  <= ge ? RW'(r2 - (RW+1)'(den)) : r2[RW-1:0];
            lq_ff[s]   <= {lq_src[QW-2:0], ge};
            side_ff[s] <= side_src;
         end
      end
   endgenerate

   assign out_valid = v_ff[QW-1];
   assign out_quot  = lq_ff[QW-1];
   assign out_side  = side_ff[QW-1];

endmodule

@@ hdl/aspect_fit_zoom_pan_resampler.sv @@
// ---------------------------------------------------------------------------
// aspect_fit_zoom_pan_resampler
// Nearest-neighbor scaler geometry: window pixel in, source pixel, screen
// pixel and visible flag out.
//
//   channel  ports                          transfer
//   req      start, busy, req_data          start && !busy
//   rsp      rsp_valid, rsp_data            rsp_valid, one cycle
//   csr      csr_valid, csr_ready, index    csr_valid && csr_ready
//
// One transaction per clock while busy is low.
// The two per-pixel divisions run through 16-stage divider pipelines.
// After reset and after each register write, busy is high
// while a bit-serial divider recomputes the fitted geometry.
// Reset is synchronous and active high; results cannot be stalled.
// ---------------------------------------------------------------------------
`include "aspect_fit_zoom_pan_resampler_assert.svh"

module aspect_fit_zoom_pan_resampler import afzp_pkg::*; #(
   parameter int SCREEN_WIDTH   = 320,
   parameter int SCREEN_HEIGHT  = 240,
   parameter int CONTENT_TOP    = 23,
   parameter int CONTENT_HEIGHT = 195
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  afzp_req_type         req_data,
   output logic                 rsp_valid,
   output afzp_rsp_type         rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   localparam int NUM_W = GEO_W + 1;
   localparam int PRD_W = NUM_W + IMG_W;

   afzp_geo_type geo;

   logic             s1_valid_ff;
   afzp_req_type     s1_req_ff;
   logic             s2_valid_ff;
   logic [NUM_W-1:0] s2_nx_ff, s2_ny_ff;
   logic [8:0]       s2_sx_ff;
   logic [7:0]       s2_sy_ff;
   logic             s2_vis_ff;
   logic             s3_valid_ff;
   logic [PRD_W-1:0] s3_px_ff, s3_py_ff;
   logic [16:0]      s3_side_ff;
   logic             s3_vis_ff;

   logic [GEO_W-1:0] sx, sy;
   logic             vis;
   logic             x_valid, y_valid;
   logic [15:0]      qx, qy;
   logic [16:0]      x_side;
   logic             y_vis;
   logic             rsp_valid_ff;
   afzp_rsp_type     rsp_ff;

   assign csr_ready = 1'b1;

   afzp_geom #(
      .SCREEN_WIDTH   (SCREEN_WIDTH),
      .SCREEN_HEIGHT  (SCREEN_HEIGHT),
      .CONTENT_TOP    (CONTENT_TOP),
      .CONTENT_HEIGHT (CONTENT_HEIGHT)
   ) u_geom (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .busy      (busy),
      .geo       (geo)
   );

   // stage 1: capture the transaction
   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else       s1_valid_ff <= start && !busy;
   end

   always_ff @(posedge clock) begin
      s1_req_ff <= req_data;
   end

   // screen position and clip
   always_comb begin
      sx  = geo.ddx + GEO_W'(s1_req_ff.win_x);
      sy  = geo.ddy + GEO_W'(s1_req_ff.win_y);
      vis = (GEO_W'(s1_req_ff.win_x) < geo.svw) && (GEO_W'(s1_req_ff.win_y) < geo.svh) &&
            (sx < geo.tw) && (sy >= geo.ty) && (sy < geo.tyth);
   end

   // stage 2: panned virtual coordinate
   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else       s2_valid_ff <= s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      s2_nx_ff  <= NUM_W'(geo.px) + NUM_W'(s1_req_ff.win_x);
      s2_ny_ff  <= NUM_W'(geo.py) + NUM_W'(s1_req_ff.win_y);
      s2_sx_ff  <= sx[8:0];
      s2_sy_ff  <= sy[7:0];
      s2_vis_ff <= vis;
   end

   // stage 3: scale by the native size
   always_ff @(posedge clock) begin
      if (reset) s3_valid_ff <= 1'b0;
      else       s3_valid_ff <= s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      s3_px_ff   <= PRD_W'(s2_nx_ff) * PRD_W'(geo.iw);
      s3_py_ff   <= PRD_W'(s2_ny_ff) * PRD_W'(geo.ih);
      s3_side_ff <= {s2_sx_ff, s2_sy_ff};
      s3_vis_ff  <= s2_vis_ff;
   end

   // divide by the virtual size
   afzp_div_pipe #(.DW(GEO_W), .QW(16), .SW(17)) u_div_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid_ff),
      .in_num    (s3_px_ff),
      .den       (geo.vw),
      .in_side   (s3_side_ff),
      .out_valid (x_valid),
      .out_quot  (qx),
      .out_side  (x_side)
   );

   afzp_div_pipe #(.DW(GEO_W), .QW(16), .SW(1)) u_div_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid_ff),
      .in_num    (s3_py_ff),
      .den       (geo.vh),
      .in_side   (s3_vis_ff),
      .out_valid (y_valid),
      .out_quot  (qy),
      .out_side  (y_vis)
   );

   // output register; hidden pixels report all zero
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= x_valid;
   end

   always_ff @(posedge clock) begin
      rsp_ff.src_x   <= y_vis ? qx : '0;
      rsp_ff.src_y   <= y_vis ? qy : '0;
      rsp_ff.scr_x   <= y_vis ? x_side[16:8] : '0;
      rsp_ff.scr_y   <= y_vis ? x_side[7:0] : '0;
      rsp_ff.visible <= y_vis;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `AFZP_ASSERT_NEXT(a_csr_recompute, clock, reset, csr_valid && csr_ready, busy)
   `AFZP_ASSERT_NEXT(a_accept_enters, clock, reset, start && !busy, s1_valid_ff)
   `AFZP_ASSERT_IMPL(a_lanes_aligned, clock, reset, x_valid || y_valid, x_valid && y_valid)
   `AFZP_ASSERT_IMPL(a_hidden_zero, clock, reset, rsp_valid && !rsp_data.visible, rsp_data.src_x == 16'd0 && rsp_data.scr_y == 8'd0)

endmodule

@@ tb/sv/testbench.sv @@
// ---------------------------------------------------------------------------
// testbench
// Drives window pixel transactions and register writes into the aspect-fit
// zoom/pan resampler and checks every result against a local geometry model.
// ---------------------------------------------------------------------------
module testbench;
   import afzp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SW = 320;
   localparam int SH = 240;
   localparam int CT = 23;
   localparam int CH = 195;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE = 60;

   // scoreboard: predicts results and checks them in order
   class pixel_map_board;
      logic [15:0] img_w, img_h;
      logic        full;
      logic [1:0]  zoom;
      logic [11:0] pan_h, pan_v;
      afzp_rsp_type pending[$];
      int errors;

      function new();
         img_w = 1; img_h = 1; full = 0; zoom = 0; pan_h = 0; pan_v = 0;
         errors = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [15:0] val);
         case (idx)
            REG_IMAGE_WIDTH:  img_w = val;
            REG_IMAGE_HEIGHT: img_h = val;
            REG_FULLSCREEN:   full  = val[0];
            REG_ZOOM_STEP:    zoom  = val[1:0];
            REG_PAN_X:        pan_h = val[11:0];
            REG_PAN_Y:        pan_v = val[11:0];
            default: ;
         endcase
      endfunction

      function afzp_rsp_type map_pixel(afzp_req_type r);
         longint unsigned ty, tw, th, iw, ih, bw, bh, vw, vh, svw, svh;
         longint unsigned px, py, ddx, ddy, sx, sy, wx, wy;
         bit band, vis;
         afzp_rsp_type o;
         wx = r.win_x; wy = r.win_y;
         band = !(full || zoom != 0);
         ty = band ? CT : 0;
         tw = SW;
         th = band ? CH : SH;
         iw = (img_w == 0) ? 1 : img_w;
         ih = (img_h == 0) ? 1 : img_h;
         if (iw * th >= ih * tw) begin
            bw = tw; bh = ih * tw / iw;
         end else begin
            bh = th; bw = iw * th / ih;
         end
         if (bw == 0) bw = 1;
         if (bh == 0) bh = 1;
         vw = bw << zoom;
         vh = bh << zoom;
         svw = (vw < tw) ? vw : tw;
         svh = (vh < th) ? vh : th;
         px = (vw > tw) ? vw - tw : 0;
         if (pan_h < px) px = pan_h;
         py = (vh > th) ? vh - th : 0;
         if (pan_v < py) py = pan_v;
         ddx = (tw - svw) / 2;
         ddy = ty + (th - svh) / 2;
         sx = ddx + wx;
         sy = ddy + wy;
         vis = wx < svw && wy < svh && sx < tw && sy >= ty && sy < ty + th;
         o = '0;
         if (vis) begin
            o.src_x = 16'((px + wx) * iw / vw);
            o.src_y = 16'((py + wy) * ih / vh);
            o.scr_x = 9'(sx);
            o.scr_y = 8'(sy);
            o.visible = 1'b1;
         end
         return o;
      endfunction

      function void note_pixel(afzp_req_type r);
         pending.push_back(map_pixel(r));
      endfunction

      function void check_result(afzp_rsp_type got);
         afzp_rsp_type exp_r;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", $realtime, got);
            errors++;
            return;
         end
         exp_r = pending.pop_front();
         if (got.src_x !== exp_r.src_x)
            $display("%0t: src_x exp %0d got %0d", $realtime, exp_r.src_x, got.src_x);
         if (got.src_y !== exp_r.src_y)
            $display("%0t: src_y exp %0d got %0d", $realtime, exp_r.src_y, got.src_y);
         if (got.scr_x !== exp_r.scr_x)
            $display("%0t: scr_x exp %0d got %0d", $realtime, exp_r.scr_x, got.scr_x);
         if (got.scr_y !== exp_r.scr_y)
            $display("%0t: scr_y exp %0d got %0d", $realtime, exp_r.scr_y, got.scr_y);
         if (got.visible !== exp_r.visible)
            $display("%0t: visible exp %0d got %0d", $realtime, exp_r.visible, got.visible);
         if (got !== exp_r) errors++;
      endfunction
   endclass

   logic clock = 0, reset = 1, start = 0, csr_valid = 0;
   logic busy, rsp_valid, csr_ready;
   afzp_req_type req_data = '0;
   afzp_rsp_type rsp_data;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;
   pixel_map_board board = new();
   int cycles = 0;

   aspect_fit_zoom_pan_resampler u_top (
      .clock, .reset, .start, .busy, .req_data, .rsp_valid, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata
   );

   initial forever #6 clock = ~clock;

   // result monitor and watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid) board.check_result(rsp_data);
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic idle_cycles(int n);
      repeat (n) @(posedge clock);
   endtask

   // start drops only when a gap follows, so back-to-back pixels keep it high
   task automatic random_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return;
      start <= 1'b0;
      if (r < 95) idle_cycles($urandom_range(1, 3));
      else idle_cycles($urandom_range(10, 40));
   endtask

   // one pixel transaction; start stays high until accepted
   task automatic send_pixel(logic [8:0] wx, logic [7:0] wy);
      afzp_req_type r;
      r.win_x = wx; r.win_y = wy;
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_pixel(r);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      idle_cycles(SETTLE);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [15:0] val);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.write_reg(idx, val);
      csr_valid <= 1'b0;
   endtask

   task automatic random_pixel();
      if ($urandom_range(0, 9) == 0)
         send_pixel(9'($urandom), 8'($urandom));
      else
         send_pixel(9'($urandom_range(0, SW - 1)), 8'($urandom_range(0, SH - 1)));
      random_gap();
   endtask

   task automatic random_config();
      logic [15:0] w, h;
      int k;
      k = $urandom_range(0, 5);
      w = (k == 0) ? 16'hFFFF : (k == 1) ? 16'd0 : 16'($urandom_range(1, 2000));
      k = $urandom_range(0, 5);
      h = (k == 0) ? 16'hFFFF : (k == 1) ? 16'd0 : 16'($urandom_range(1, 2000));
      write_reg(REG_IMAGE_WIDTH, w);
      write_reg(REG_IMAGE_HEIGHT, h);
      write_reg(REG_FULLSCREEN, 16'($urandom_range(0, 1)));
      write_reg(REG_ZOOM_STEP, 16'($urandom_range(0, 3)));
      write_reg(REG_PAN_X, ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom));
      write_reg(REG_PAN_Y, ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom));
      if ($urandom_range(0, 7) == 0) write_reg(3'd6 + 3'($urandom_range(0, 1)), 16'($urandom));
   endtask

   initial begin
      idle_cycles(8);
      reset <= 1'b0;
      // directed: reset setting, corner pixels
      send_pixel(0, 0);
      send_pixel(319, 239);
      send_pixel(9'h1FF, 8'hFF);
      drain();
      // wide image, zoomed, pan beyond range
      write_reg(REG_IMAGE_WIDTH, 16'hFFFF);
      write_reg(REG_IMAGE_HEIGHT, 16'd0);
      write_reg(REG_ZOOM_STEP, 16'd3);
      write_reg(REG_PAN_X, 16'h0FFF);
      write_reg(REG_PAN_Y, 16'h0FFF);
      send_pixel(0, 0);
      send_pixel(319, 239);
      send_pixel(100, 0);
      // tall image, fullscreen, unknown index
      write_reg(REG_IMAGE_WIDTH, 16'd1);
      write_reg(REG_IMAGE_HEIGHT, 16'hFFFF);
      write_reg(REG_ZOOM_STEP, 16'd0);
      write_reg(REG_FULLSCREEN, 16'd1);
      write_reg(3'd7, 16'h1234);
      send_pixel(0, 0);
      send_pixel(0, 239);
      send_pixel(160, 120);
      // content band
      write_reg(REG_FULLSCREEN, 16'd0);
      write_reg(REG_IMAGE_WIDTH, 16'd640);
      write_reg(REG_IMAGE_HEIGHT, 16'd480);
      send_pixel(0, 0);
      send_pixel(319, 194);
      send_pixel(0, 195);
      // random phases
      for (int phase = 0; phase < 31; phase++) begin
         random_config();
         for (int i = 0; i < 50; i++) random_pixel();
      end
      drain();
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
